[design/swmm_pkg.sv]
// Package for the sliding-window min/max buffer.
// Holds the transaction structs, command and register codes and the sequencer states.
// No dependencies.
package swmm_pkg;

  // Field widths of the transactions and registers.
  localparam int SAMPLE_W  = 16;
  localparam int LEN_W     = 11;
  localparam int IDX_W     = 11;
  localparam int CFG_IDX_W = 1;

  // Sample extremes, used as the empty-window values.
  localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = {1'b0, {(SAMPLE_W-1){1'b1}}};
  localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_W-1){1'b0}}};

  // Register indexes of the configuration port.
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_LENGTH = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_BUFFER_MODE   = 1'b1;

  // Reset value of the window length register.
  localparam logic [LEN_W-1:0] WINDOW_LENGTH_RST = 11'd1024;

  // Buffer modes.
  localparam logic MODE_ROLLING = 1'b0;
  localparam logic MODE_FIFO    = 1'b1;

  typedef enum logic [1:0] {
    CMD_PUSH  = 2'd0,
    CMD_CLEAR = 2'd1,
    CMD_READ  = 2'd2,
    CMD_NOP   = 2'd3
  } cmd_t;

  typedef struct packed {
    cmd_t                        command;
    logic signed [SAMPLE_W-1:0]  sample;
    logic        [IDX_W-1:0]     read_index;
  } in_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0]  window_min;
    logic signed [SAMPLE_W-1:0]  window_max;
    logic                        window_has_data;
    logic signed [SAMPLE_W-1:0]  read_value;
    logic                        read_valid;
  } out_t;

  // One slot of the sample store: valid mark and sample.
  typedef struct packed {
    logic                        valid;
    logic signed [SAMPLE_W-1:0]  sample;
  } slot_t;

  // Control of the min/max unit.
  typedef struct packed {
    logic init;
    logic fold;
  } ext_ctl_t;

  typedef enum logic [3:0] {
    ST_INIT,
    ST_IDLE,
    ST_CLEAR,
    ST_PUSH_RD,
    ST_PUSH_WR,
    ST_SCAN,
    ST_SCAN_LAST,
    ST_MOD,
    ST_READ_ADDR,
    ST_READ_DATA,
    ST_DONE
  } state_t;

endpackage

[design/swmm_store.sv]
// Sample store of the sliding-window min/max buffer: one write port, one registered read port.
// Each word carries a valid mark and a sample. Depends on swmm_pkg.
module swmm_store import swmm_pkg::*; #(
  parameter int DEPTH = 1024,
  parameter int AW    = 10
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  slot_t         wr_data,
  input  logic [AW-1:0] rd_addr,
  output slot_t         rd_data
);

  slot_t mem [DEPTH];
  slot_t rd_data_r;

  // Write port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Read port, data registered.
  always_ff @(posedge clk) begin
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

[design/swmm_extreme.sv]
// Running minimum/maximum unit of the sliding-window buffer.
// Holds the window extremes and folds one sample per cycle while its fold control is set. Depends on swmm_pkg.
module swmm_extreme import swmm_pkg::*; (
  input  logic                       clk,
  input  logic                       rst_n,
  input  ext_ctl_t                   ctl,
  input  logic                       fold_valid,
  input  logic signed [SAMPLE_W-1:0] fold_sample,
  output logic signed [SAMPLE_W-1:0] min_val,
  output logic signed [SAMPLE_W-1:0] max_val,
  output logic                       any_val
);

  logic signed [SAMPLE_W-1:0] min_r;
  logic signed [SAMPLE_W-1:0] max_r;
  logic                       any_r;
  logic                       lower;
  logic                       higher;

  // The shared compare pair.
  assign lower  = fold_sample < min_r;
  assign higher = fold_sample > max_r;

  // Init restores the empty-window values; fold takes in one valid sample.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_r <= SAMPLE_MAX;
      max_r <= SAMPLE_MIN;
      any_r <= 1'b0;
    end else if (ctl.init) begin
      min_r <= SAMPLE_MAX;
      max_r <= SAMPLE_MIN;
      any_r <= 1'b0;
    end else if (ctl.fold && fold_valid) begin
      if (lower) begin
        min_r <= fold_sample;
      end
      if (higher) begin
        max_r <= fold_sample;
      end
      any_r <= 1'b1;
    end
  end

  assign min_val = min_r;
  assign max_val = max_r;
  assign any_val = any_r;

endmodule

[design/swmm_mod.sv]
// Bit-serial remainder unit of the sliding-window buffer.
// Reduces the read index modulo the window length, one dividend bit per cycle. Depends on swmm_pkg.
module swmm_mod import swmm_pkg::*; #(
  parameter int LW = 11
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [IDX_W-1:0] dividend,
  input  logic [LW-1:0]    divisor,
  output logic             done,
  output logic [LW-1:0]    rem
);

  localparam int CW = $clog2(IDX_W + 1);

  logic             busy_r;
  logic             done_r;
  logic [CW-1:0]    cnt_r;
  logic [IDX_W-1:0] quo_r;
  logic [LW-1:0]    rem_r;
  logic [LW:0]      shifted;
  logic [LW:0]      diff;
  logic             ge;
  logic [LW-1:0]    rem_step;

  // One restoring step: shift in the next dividend bit, subtract if it fits.
  assign shifted  = {rem_r, quo_r[IDX_W-1]};
  assign diff     = shifted - {1'b0, divisor};
  assign ge       = shifted >= {1'b0, divisor};
  assign rem_step = ge ? diff[LW-1:0] : shifted[LW-1:0];

  // Step counter and status.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CW'(IDX_W);
      end else if (busy_r) begin
        cnt_r <= cnt_r - CW'(1);
        if (cnt_r == CW'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // Dividend and partial remainder.
  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= dividend;
      rem_r <= '0;
    end else if (busy_r) begin
      quo_r <= {quo_r[IDX_W-2:0], 1'b0};
      rem_r <= rem_step;
    end
  end

  assign done = done_r;
  assign rem  = rem_r;

endmodule

[design/sliding_window_min_max_buffer.sv]
// Sliding-window min/max buffer, top level: sequencer, pointers and output register.
// A push reads the evicted slot, then writes the new sample; when the evicted sample was an
// extreme, the window is rescanned one slot per cycle. A read runs 11 remainder steps, then
// addresses the store and takes its data; a clear runs over the store one slot per cycle; a no
// operation goes straight to the result. Reset is synchronous, active low; after it a clearing
// pass runs over the store with in_stall high, configuration writes are taken meanwhile. Depends on swmm_pkg.
module sliding_window_min_max_buffer import swmm_pkg::*; #(
  parameter int DEPTH = 1024
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  in_t                  in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output out_t                 out_data,
  input  logic                 cfg_write_en,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [LEN_W-1:0]     cfg_data
);

  localparam int AW = $clog2(DEPTH);
  localparam int LW = (AW + 1 > LEN_W) ? AW + 1 : LEN_W;
  localparam logic [AW-1:0] LAST_SLOT = AW'(DEPTH - 1);
  localparam logic [LW-1:0] DEPTH_LEN = LW'(DEPTH);

  state_t                     state_r;
  state_t                     state_nxt;
  logic [LEN_W-1:0]           window_length_r;
  logic                       buffer_mode_r;
  logic [LW-1:0]              len_r;
  logic [AW-1:0]              wp_r;
  logic                       full_r;
  logic [AW-1:0]              cnt_r;
  logic                       scan_pend_r;
  logic signed [SAMPLE_W-1:0] sample_r;
  logic signed [SAMPLE_W-1:0] rval_r;
  logic                       rvalid_r;
  logic                       out_valid_r;
  out_t                       out_data_r;

  logic                       in_accept;
  logic                       out_free;
  logic [LW-1:0]              wl_ext;
  logic [LW-1:0]              eff_len;
  logic [AW-1:0]              pos;
  logic [LW-1:0]              pos_inc;
  logic                       wrap;
  logic                       last_scan;
  logic                       last_slot;
  logic [LW-1:0]              sum;
  logic [LW-1:0]              wrapped;
  logic [AW-1:0]              phys;
  logic                       hit;

  logic                       mem_we;
  logic [AW-1:0]              mem_waddr;
  slot_t                      mem_wdata;
  logic [AW-1:0]              mem_raddr;
  slot_t                      mem_rdata;
  ext_ctl_t                   ext_ctl;
  logic                       fold_valid;
  logic signed [SAMPLE_W-1:0] fold_sample;
  logic signed [SAMPLE_W-1:0] ext_min;
  logic signed [SAMPLE_W-1:0] ext_max;
  logic                       ext_any;
  logic                       mod_start;
  logic                       mod_done;
  logic [LW-1:0]              mod_rem;

  assign in_stall  = (state_r != ST_IDLE);
  assign in_accept = in_valid && !in_stall;
  assign out_free  = !out_valid_r || !out_stall;

  // Effective window length: zero acts as one, above the depth acts as the depth.
  assign wl_ext  = LW'(window_length_r);
  assign eff_len = (wl_ext == '0) ? LW'(1) : ((wl_ext > DEPTH_LEN) ? DEPTH_LEN : wl_ext);

  // Write position and its successor.
  assign pos     = (LW'(wp_r) < len_r) ? wp_r : '0;
  assign pos_inc = LW'(pos) + LW'(1);
  assign wrap    = pos_inc >= len_r;

  assign last_scan = LW'(cnt_r) == (len_r - LW'(1));
  assign last_slot = cnt_r == LAST_SLOT;

  // Oldest-first address: both terms are below the length, so one subtract wraps it.
  assign sum     = LW'(pos) + mod_rem;
  assign wrapped = (sum >= len_r) ? (sum - len_r) : sum;
  assign phys    = (buffer_mode_r == MODE_FIFO && full_r) ? wrapped[AW-1:0] : mod_rem[AW-1:0];

  // The evicted sample is valid and equals one of the extremes.
  assign hit = mem_rdata.valid && (mem_rdata.sample == ext_min || mem_rdata.sample == ext_max);

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_INIT: begin
        if (last_slot) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_accept) begin
          unique case (in_data.command)
            CMD_PUSH:  state_nxt = ST_PUSH_RD;
            CMD_CLEAR: state_nxt = ST_CLEAR;
            CMD_READ:  state_nxt = ST_MOD;
            CMD_NOP:   state_nxt = ST_DONE;
            default:   state_nxt = ST_DONE;
          endcase
        end
      end
      ST_CLEAR: begin
        if (last_slot) state_nxt = ST_DONE;
      end
      ST_PUSH_RD:   state_nxt = ST_PUSH_WR;
      ST_PUSH_WR:   state_nxt = hit ? ST_SCAN : ST_DONE;
      ST_SCAN: begin
        if (last_scan) state_nxt = ST_SCAN_LAST;
      end
      ST_SCAN_LAST: state_nxt = ST_DONE;
      ST_MOD: begin
        if (mod_done) state_nxt = ST_READ_ADDR;
      end
      ST_READ_ADDR: state_nxt = ST_READ_DATA;
      ST_READ_DATA: state_nxt = ST_DONE;
      ST_DONE: begin
        if (out_free) state_nxt = ST_IDLE;
      end
      default:      state_nxt = ST_IDLE;
    endcase
  end

  // Sequencer outputs: store ports, min/max unit and remainder start.
  always_comb begin
    mem_we           = 1'b0;
    mem_waddr        = cnt_r;
    mem_wdata.valid  = 1'b0;
    mem_wdata.sample = '0;
    mem_raddr        = cnt_r;
    ext_ctl.init     = 1'b0;
    ext_ctl.fold     = scan_pend_r;
    fold_valid       = scan_pend_r ? mem_rdata.valid : 1'b1;
    fold_sample      = scan_pend_r ? mem_rdata.sample : sample_r;
    mod_start        = in_accept && (in_data.command == CMD_READ);
    unique case (state_r)
      ST_INIT: begin
        mem_we = 1'b1;
      end
      ST_CLEAR: begin
        mem_we       = 1'b1;
        ext_ctl.init = last_slot;
      end
      ST_PUSH_RD: begin
        mem_raddr = pos;
      end
      ST_PUSH_WR: begin
        mem_we           = 1'b1;
        mem_waddr        = pos;
        mem_wdata.valid  = 1'b1;
        mem_wdata.sample = sample_r;
        ext_ctl.init     = hit;
        ext_ctl.fold     = !hit;
      end
      ST_READ_ADDR: begin
        mem_raddr = phys;
      end
      default: begin
      end
    endcase
  end

  // Control registers: state, counters, pointers, configuration and output valid.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r         <= ST_INIT;
      cnt_r           <= '0;
      wp_r            <= '0;
      full_r          <= 1'b0;
      scan_pend_r     <= 1'b0;
      window_length_r <= WINDOW_LENGTH_RST;
      buffer_mode_r   <= MODE_ROLLING;
      out_valid_r     <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      scan_pend_r <= (state_r == ST_SCAN);

      // Configuration writes.
      if (cfg_write_en) begin
        if (cfg_index == REG_WINDOW_LENGTH) begin
          window_length_r <= cfg_data;
        end else if (cfg_index == REG_BUFFER_MODE) begin
          buffer_mode_r <= cfg_data[0];
        end
      end

      // Slot counter shared by the clearing pass and the rescan.
      unique case (state_r)
        ST_INIT, ST_CLEAR:   cnt_r <= last_slot ? '0 : cnt_r + AW'(1);
        ST_SCAN:             cnt_r <= cnt_r + AW'(1);
        ST_IDLE, ST_PUSH_WR: cnt_r <= '0;
        default: begin
        end
      endcase

      // Write pointer and full flag.
      if (state_r == ST_PUSH_WR) begin
        wp_r <= wrap ? '0 : pos_inc[AW-1:0];
        if (wrap) begin
          full_r <= 1'b1;
        end
      end else if (state_r == ST_CLEAR && last_slot) begin
        wp_r   <= '0;
        full_r <= 1'b0;
      end

      // Output register.
      if (state_r == ST_DONE && out_free) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (in_accept) begin
      sample_r <= in_data.sample;
      len_r    <= eff_len;
      rval_r   <= '0;
      rvalid_r <= 1'b0;
    end else if (state_r == ST_READ_DATA && mem_rdata.valid) begin
      rval_r   <= mem_rdata.sample;
      rvalid_r <= 1'b1;
    end
    if (state_r == ST_DONE && out_free) begin
      out_data_r.window_min      <= ext_min;
      out_data_r.window_max      <= ext_max;
      out_data_r.window_has_data <= ext_any;
      out_data_r.read_value      <= rval_r;
      out_data_r.read_valid      <= rvalid_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  swmm_store #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_store (
    .clk     (clk),
    .wr_en   (mem_we),
    .wr_addr (mem_waddr),
    .wr_data (mem_wdata),
    .rd_addr (mem_raddr),
    .rd_data (mem_rdata)
  );

  swmm_extreme u_extreme (
    .clk         (clk),
    .rst_n       (rst_n),
    .ctl         (ext_ctl),
    .fold_valid  (fold_valid),
    .fold_sample (fold_sample),
    .min_val     (ext_min),
    .max_val     (ext_max),
    .any_val     (ext_any)
  );

  swmm_mod #(
    .LW (LW)
  ) u_mod (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (mod_start),
    .dividend (in_data.read_index),
    .divisor  (len_r),
    .done     (mod_done),
    .rem      (mod_rem)
  );

endmodule

[dv/swmm_checker.sv]
// Scoreboard for the sliding-window min/max buffer: predicts each result from the accepted
// transactions and configuration writes, and compares it with the block's output.
// Depends on swmm_pkg.
module swmm_checker import swmm_pkg::*; #(
  parameter int DEPTH = 1024
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  input  logic                 in_stall,
  input  in_t                  in_data,
  input  logic                 out_valid,
  input  logic                 out_stall,
  input  out_t                 out_data,
  input  logic                 cfg_write_en,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [LEN_W-1:0]     cfg_data,
  output int                   mismatches,
  output int                   pending
);
  timeunit 1ns;
  timeprecision 1ps;

  // Shadow copy of the window and of the registers.
  logic signed [SAMPLE_W-1:0] slot_sample [DEPTH];
  bit                         slot_filled [DEPTH];
  int unsigned                write_slot;
  bit                         wrapped;
  logic signed [SAMPLE_W-1:0] win_min;
  logic signed [SAMPLE_W-1:0] win_max;
  bit                         win_has_data;
  logic [LEN_W-1:0]           length_reg;
  logic                       mode_reg;

  out_t expected_results [$];
  int   error_count;
  int   result_count;

  task automatic report_mismatch(string msg);
    error_count++;
    $display("ERROR at %0t: %s", $time, msg);
  endtask

  task automatic check_field(string field, logic [SAMPLE_W-1:0] got,
                             logic [SAMPLE_W-1:0] want);
    if (got !== want) begin
      report_mismatch($sformatf("result %0d, %s: got %0d, expected %0d",
                                result_count, field, $signed(got), $signed(want)));
    end
  endtask

  // Empties the window: no valid slot, pointer home, extremes at their empty values.
  function automatic void clear_window();
    foreach (slot_filled[k]) slot_filled[k] = 1'b0;
    write_slot   = 0;
    wrapped      = 1'b0;
    win_min      = SAMPLE_MAX;
    win_max      = SAMPLE_MIN;
    win_has_data = 1'b0;
  endfunction

  // Applies one transaction to the shadow window and returns the result it produces.
  function automatic out_t predict_window_result(in_t item);
    int unsigned                span;
    int unsigned                slot;
    int unsigned                idx;
    logic signed [SAMPLE_W-1:0] evicted;
    bit                         evicted_filled;
    out_t                       res;
    res = '0;
    // A zero length behaves as one, an oversized one as the full depth.
    if (length_reg == 0) span = 1;
    else if (length_reg > DEPTH) span = DEPTH;
    else span = length_reg;

    case (item.command)
      CMD_PUSH: begin
        // A pointer left beyond a shortened window restarts at slot zero.
        slot           = (write_slot < span) ? write_slot : 0;
        evicted        = slot_sample[slot];
        evicted_filled = slot_filled[slot];
        slot_sample[slot] = item.sample;
        slot_filled[slot] = 1'b1;
        slot++;
        if (slot >= span) begin
          slot    = 0;
          wrapped = 1'b1;
        end
        write_slot = slot;
        // Losing a current extreme forces a rescan of the live slots only.
        if (evicted_filled && (evicted == win_min || evicted == win_max)) begin
          win_min      = SAMPLE_MAX;
          win_max      = SAMPLE_MIN;
          win_has_data = 1'b0;
          for (int k = 0; k < span; k++) begin
            if (slot_filled[k]) begin
              if (slot_sample[k] < win_min) win_min = slot_sample[k];
              if (slot_sample[k] > win_max) win_max = slot_sample[k];
              win_has_data = 1'b1;
            end
          end
        end else begin
          if (item.sample < win_min) win_min = item.sample;
          if (item.sample > win_max) win_max = item.sample;
          win_has_data = 1'b1;
        end
      end
      CMD_CLEAR: clear_window();
      CMD_READ: begin
        // Fifo order starts at the oldest slot, which only differs once the window wrapped.
        idx  = item.read_index % span;
        slot = idx;
        if (mode_reg == MODE_FIFO && wrapped) begin
          slot = (((write_slot < span) ? write_slot : 0) + idx) % span;
        end
        if (slot_filled[slot]) begin
          res.read_value = slot_sample[slot];
          res.read_valid = 1'b1;
        end
      end
      default: ;
    endcase

    res.window_min      = win_min;
    res.window_max      = win_max;
    res.window_has_data = win_has_data;
    return res;
  endfunction

  // Track registers and transactions; results are checked before new items are queued.
  always @(posedge clk) begin
    out_t want;
    if (!rst_n) begin
      clear_window();
      length_reg = WINDOW_LENGTH_RST;
      mode_reg   = MODE_ROLLING;
      expected_results.delete();
    end else begin
      if (cfg_write_en) begin
        case (cfg_index)
          REG_WINDOW_LENGTH: length_reg = cfg_data;
          REG_BUFFER_MODE:   mode_reg   = cfg_data[0];
          default: ;
        endcase
      end
      if (out_valid && !out_stall) begin
        result_count++;
        if (expected_results.size() == 0) begin
          report_mismatch($sformatf("result %0d arrived with nothing expected: %p",
                                    result_count, out_data));
        end else begin
          want = expected_results.pop_front();
          check_field("window_min", out_data.window_min, want.window_min);
          check_field("window_max", out_data.window_max, want.window_max);
          check_field("window_has_data", SAMPLE_W'(out_data.window_has_data),
                      SAMPLE_W'(want.window_has_data));
          check_field("read_value", out_data.read_value, want.read_value);
          check_field("read_valid", SAMPLE_W'(out_data.read_valid),
                      SAMPLE_W'(want.read_valid));
        end
      end
      if (in_valid && !in_stall) begin
        expected_results.push_back(predict_window_result(in_data));
      end
    end
    pending    <= expected_results.size();
    mismatches <= error_count;
  end

endmodule

[dv/tb.sv]
// Testbench top for the sliding-window min/max buffer: clock, reset, configuration writes,
// directed and random transactions with random idling, and the final verdict.
// Depends on swmm_pkg, swmm_checker and the block itself.
module tb import swmm_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DEPTH          = 1024;
  localparam int ITEMS_TOTAL    = 580;
  localparam int QUIET_TAIL     = 80;
  // The longest correct quiet stretch is the clearing pass after reset, a clear or a full
  // rescan, plus a receiver stall; the limit is several times that.
  localparam int WATCHDOG_LIMIT = 8000;
  localparam int DRAIN_CYCLES   = 40;

  logic                 clk = 1'b0;
  logic                 rst_n;
  logic                 in_valid;
  logic                 in_stall;
  in_t                  in_data;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  out_t                 out_data;
  logic                 cfg_write_en;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [LEN_W-1:0]     cfg_data;
  int                   mismatches;
  int                   pending;

  int idle_cycles;
  bit quiet;
  int sent, n_push, n_read, n_clear, n_nop, n_settings;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  sliding_window_min_max_buffer #(.DEPTH(DEPTH)) dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_data      (in_data),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_data     (out_data),
    .cfg_write_en (cfg_write_en),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  swmm_checker #(.DEPTH(DEPTH)) u_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_data      (in_data),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_data     (out_data),
    .cfg_write_en (cfg_write_en),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .mismatches   (mismatches),
    .pending      (pending)
  );

  function automatic in_t make_item(cmd_t op, logic signed [SAMPLE_W-1:0] value,
                                    logic [IDX_W-1:0] index);
    in_t item;
    item.command    = op;
    item.sample     = value;
    item.read_index = index;
    return item;
  endfunction

  // Offers one transaction, sometimes after an idle burst, and waits for its acceptance.
  task automatic send_item(input in_t item);
    quiet = (sent >= ITEMS_TOTAL - QUIET_TAIL);
    if (!quiet && $urandom_range(0, 7) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sent++;
    case (item.command)
      CMD_PUSH:  n_push++;
      CMD_READ:  n_read++;
      CMD_CLEAR: n_clear++;
      default:   n_nop++;
    endcase
  endtask

  // Holds the sender off until every outstanding result has been taken.
  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  // Writes the length register, then the mode register; called after a drain, or during the clearing pass after reset.
  task automatic config_window(input logic [LEN_W-1:0] len, input logic mode);
    cfg_write_en <= 1'b1;
    cfg_index    <= REG_WINDOW_LENGTH;
    cfg_data     <= len;
    @(posedge clk);
    cfg_index    <= REG_BUFFER_MODE;
    cfg_data     <= LEN_W'(mode);
    @(posedge clk);
    cfg_write_en <= 1'b0;
    n_settings++;
  endtask

  // Receiver stalls in random bursts, none in the final part of the run.
  always begin
    @(posedge clk);
    if (!quiet && $urandom_range(0, 5) == 0) begin
      out_stall <= 1'b1;
      repeat ($urandom_range(1, 11)) @(posedge clk);
      out_stall <= 1'b0;
    end
  end

  // Watchdog: ends the run when no transaction moves for too long.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Watchdog expired after %0d cycles without a transaction", idle_cycles);
      $display("Simulation FAILED");
      $finish;
    end
  end

  initial begin
    in_t              item;
    int unsigned      span;
    int unsigned      r;
    logic [LEN_W-1:0] len;
    logic             mode;

    rst_n        <= 1'b0;
    in_valid     <= 1'b0;
    in_data      <= '0;
    cfg_write_en <= 1'b0;
    cfg_index    <= REG_WINDOW_LENGTH;
    cfg_data     <= '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: empty read, extreme samples, eviction of the maximum, index wrap, no-op.
    config_window(LEN_W'(4), MODE_ROLLING);
    send_item(make_item(CMD_READ, '0, '0));
    send_item(make_item(CMD_PUSH, SAMPLE_MAX, '0));
    send_item(make_item(CMD_PUSH, SAMPLE_MIN, '0));
    send_item(make_item(CMD_PUSH, 16'sd0, '0));
    send_item(make_item(CMD_PUSH, -16'sd1, '0));
    send_item(make_item(CMD_PUSH, 16'sd5, '0));
    send_item(make_item(CMD_READ, '0, 11'd2047));
    send_item(make_item(CMD_NOP, SAMPLE_MAX, 11'd2047));

    // Oldest-first reads of a full window, then leave the pointer at slot three.
    drain();
    config_window(LEN_W'(4), MODE_FIFO);
    send_item(make_item(CMD_READ, '0, 11'd0));
    send_item(make_item(CMD_READ, '0, 11'd3));
    send_item(make_item(CMD_PUSH, 16'sd7, '0));
    send_item(make_item(CMD_PUSH, 16'sd7, '0));

    // Shrink without a clear: the pointer lies beyond the length and stale slots stay.
    drain();
    config_window(LEN_W'(2), MODE_FIFO);
    send_item(make_item(CMD_PUSH, -16'sd7, '0));
    send_item(make_item(CMD_READ, '0, 11'd0));
    send_item(make_item(CMD_READ, '0, 11'd1));
    send_item(make_item(CMD_CLEAR, '0, '0));

    // A zero length acts as one slot.
    drain();
    config_window(LEN_W'(0), MODE_ROLLING);
    send_item(make_item(CMD_PUSH, 16'sd100, '0));
    send_item(make_item(CMD_PUSH, -16'sd100, '0));
    send_item(make_item(CMD_READ, '0, 11'd5));

    // An oversized length acts as the full depth; fifo read before the window fills.
    drain();
    config_window(11'd2047, MODE_FIFO);
    send_item(make_item(CMD_PUSH, SAMPLE_MIN, '0));
    send_item(make_item(CMD_READ, '0, 11'd1500));
    send_item(make_item(CMD_CLEAR, '0, '0));

    // Random phases: a setting, usually a clear, then a push-heavy mix with random content.
    while (sent < ITEMS_TOTAL) begin
      r = $urandom_range(0, 19);
      if (n_settings == 5) len = LEN_W'(DEPTH);
      else if (n_settings == 6) len = LEN_W'(1);
      else if (r == 0) len = '0;
      else if (r == 1) len = 11'd2047;
      else if (r == 2) len = LEN_W'(DEPTH);
      else if (r < 6) len = LEN_W'($urandom_range(17, 64));
      else len = LEN_W'($urandom_range(1, 16));
      mode = 1'($urandom_range(0, 1));
      if (len == 0) span = 1;
      else if (len > DEPTH) span = DEPTH;
      else span = len;

      drain();
      config_window(len, mode);
      if ($urandom_range(0, 5) != 0) send_item(make_item(CMD_CLEAR, '0, '0));

      repeat ($urandom_range(15, 40)) begin
        if (sent >= ITEMS_TOTAL) break;
        r = $urandom_range(0, 99);
        if (r < 56) item.command = CMD_PUSH;
        else if (r < 88) item.command = CMD_READ;
        else if (r < 94) item.command = CMD_NOP;
        else item.command = CMD_CLEAR;
        // Small values and extremes repeat often, so extremes get evicted and rescanned.
        case ($urandom_range(0, 2))
          0: item.sample = SAMPLE_W'($urandom);
          1: item.sample = SAMPLE_W'(int'($urandom_range(0, 8)) - 4);
          default: item.sample = $urandom_range(0, 1) ? SAMPLE_MAX : SAMPLE_MIN;
        endcase
        if ($urandom_range(0, 1)) item.read_index = IDX_W'($urandom_range(0, 2 * span - 1));
        else item.read_index = IDX_W'($urandom_range(0, 2047));
        send_item(item);
      end
    end

    drain();
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Run covered %0d transactions: %0d pushes, %0d reads, %0d clears, %0d no-ops.",
             sent, n_push, n_read, n_clear, n_nop);
    $display("It went through %0d window settings in both read orders; %0d mismatches seen.",
             n_settings, mismatches);
    if (mismatches == 0 && pending == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
